// ===== rtl/core/prqs_pkg.sv =====
// ----------------------------------------------------------------------------
// prqs_pkg
// shared constants, types and helpers of the priority ready-queue scheduler
// ----------------------------------------------------------------------------
package prqs_pkg;

   localparam int NUM_TASKS  = 16;
   localparam int NUM_LEVELS = 16;
   localparam int ID_W       = $clog2(NUM_TASKS);
   localparam int LVL_W      = $clog2(NUM_LEVELS);
   localparam int FIELD_W    = 4;
   localparam int REQ_W      = 16;
   localparam int RSP_W      = 16;

   typedef enum logic [1:0] {
      CMD_READY   = 2'd0,
      CMD_SWITCH  = 2'd1,
      CMD_YIELD   = 2'd2,
      CMD_SETPRIO = 2'd3
   } cmd_type;

   typedef struct packed {
      logic capture;
      logic push_new;
      logic push_run;
      logic pop;
      logic set_prio;
      logic load_rsp;
   } prqs_ctl_type;

   typedef struct packed {
      cmd_type req_cmd;
      cmd_type cmd;
      logic    run_active;
      logic    preempt;
      logic    rsp_free;
   } prqs_sts_type;

   function automatic logic [LVL_W-1:0] clamp_level(input logic [FIELD_W-1:0] p);
      logic [LVL_W-1:0] r;
      if (int'(p) >= NUM_LEVELS) begin
         r = LVL_W'(NUM_LEVELS - 1);
      end else begin
         r = LVL_W'(p);
      end
      return r;
   endfunction

   function automatic logic [LVL_W-1:0] lowest_level(input logic [NUM_LEVELS-1:0] m);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (m[l]) begin
            r = LVL_W'(l);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/prqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// prqs_ctrl
// command sequencer: steps each command through what it needs of push, re-queue and pop
// ----------------------------------------------------------------------------
module prqs_ctrl
   import prqs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  prqs_sts_type sts,
   output prqs_ctl_type ctl
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PUSH = 5'b00010,
      ST_REQ  = 5'b00100,
      ST_POP  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               unique case (sts.req_cmd)
                  CMD_READY:   state_in = ST_PUSH;
                  CMD_SWITCH:  state_in = sts.run_active ? ST_REQ : ST_POP;
                  CMD_YIELD:   state_in = sts.run_active ? ST_REQ : ST_DONE;
                  CMD_SETPRIO: state_in = ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_PUSH: begin
            ctl.push_new = 1'b1;
            state_in = sts.preempt ? ST_REQ : ST_DONE;
         end
         ST_REQ: begin
            ctl.push_run = 1'b1;
            state_in = (sts.cmd == CMD_SWITCH) ? ST_POP : ST_DONE;
         end
         ST_POP: begin
            ctl.pop  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ctl.set_prio = (sts.cmd == CMD_SETPRIO);
            if (sts.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/prqs_datapath.sv =====
// ----------------------------------------------------------------------------
// prqs_datapath
// per-level linked queues, ready mask, running task state and result register
// ----------------------------------------------------------------------------
module prqs_datapath
   import prqs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   input  prqs_ctl_type     ctl,
   output prqs_sts_type     sts
);

   logic [ID_W-1:0]       next_link_ff [NUM_TASKS];
   logic [ID_W-1:0]       head_ff      [NUM_LEVELS];
   logic [ID_W-1:0]       tail_ff      [NUM_LEVELS];

   cmd_type               cmd_ff, cmd_in;
   logic [FIELD_W-1:0]    id_ff, id_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic                  id_ok_ff, id_ok_in;
   logic [NUM_LEVELS-1:0] mask_ff, mask_in;
   logic [ID_W-1:0]       run_id_ff, run_id_in;
   logic [LVL_W-1:0]      run_lvl_ff, run_lvl_in;
   logic                  active_ff, active_in;
   logic                  pend_ff, pend_in;
   logic                  changed_ff, changed_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  push_en;
   logic [ID_W-1:0]       p_id;
   logic [LVL_W-1:0]      p_lvl;
   logic                  p_hit;
   logic [LVL_W-1:0]      pop_lvl;
   logic [ID_W-1:0]       pop_id;
   logic [ID_W-1:0]       pop_next;
   logic                  pop_last;
   logic                  pop_ok;
   logic [LVL_W-1:0]      tail_addr;
   logic [ID_W-1:0]       tail_rd;
   logic                  head_we;
   logic [LVL_W-1:0]      head_addr;
   logic [ID_W-1:0]       head_wd;
   logic                  link_we;

   // shared push and pop address paths
   always_comb begin
      push_en   = (ctl.push_new & id_ok_ff) | ctl.push_run;
      p_id      = ctl.push_run ? run_id_ff : ID_W'(id_ff);
      p_lvl     = ctl.push_run ? run_lvl_ff : lvl_ff;
      p_hit     = mask_ff[p_lvl];
      pop_lvl   = lowest_level(mask_ff);
      pop_ok    = ctl.pop & (mask_ff != '0);
      pop_id    = head_ff[pop_lvl];
      pop_next  = next_link_ff[pop_id];
      tail_addr = ctl.pop ? pop_lvl : p_lvl;
      tail_rd   = tail_ff[tail_addr];
      pop_last  = (pop_id == tail_rd);
      link_we   = push_en & p_hit;
      head_we   = (push_en & ~p_hit) | (pop_ok & ~pop_last);
      head_addr = pop_ok ? pop_lvl : p_lvl;
      head_wd   = pop_ok ? pop_next : p_id;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         next_link_ff[tail_rd] <= p_id;
      end
      if (head_we) begin
         head_ff[head_addr] <= head_wd;
      end
      if (push_en) begin
         tail_ff[p_lvl] <= p_id;
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      lvl_in     = lvl_ff;
      id_ok_in   = id_ok_ff;
      mask_in    = mask_ff;
      run_id_in  = run_id_ff;
      run_lvl_in = run_lvl_ff;
      active_in  = active_ff;
      pend_in    = pend_ff;
      changed_in = changed_ff;
      err_in     = err_ff;

      if (ctl.capture) begin
         cmd_in     = cmd_type'(req_tdata[1:0]);
         id_in      = req_tdata[2 +: FIELD_W];
         lvl_in     = clamp_level(req_tdata[2+FIELD_W +: FIELD_W]);
         id_ok_in   = (int'(req_tdata[2 +: FIELD_W]) < NUM_TASKS);
         pend_in    = (cmd_type'(req_tdata[1:0]) == CMD_YIELD);
         changed_in = 1'b0;
         err_in     = 1'b0;
      end
      if (push_en) begin
         mask_in[p_lvl] = 1'b1;
      end
      if (ctl.push_run) begin
         active_in = 1'b0;
         if (cmd_ff == CMD_READY) begin
            pend_in = 1'b1;
         end
      end
      if (ctl.pop) begin
         if (mask_ff == '0) begin
            err_in = 1'b1;
         end else begin
            if (pop_last) begin
               mask_in[pop_lvl] = 1'b0;
            end
            run_id_in  = pop_id;
            run_lvl_in = pop_lvl;
            active_in  = 1'b1;
            changed_in = (pop_id != run_id_ff);
         end
      end
      if (ctl.set_prio) begin
         run_lvl_in = lvl_ff;
      end
   end

   // result word
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0 +: FIELD_W]         = FIELD_W'(run_id_in);
      rsp_data_in[FIELD_W +: FIELD_W]   = FIELD_W'(run_lvl_in);
      rsp_data_in[2*FIELD_W]            = pend_ff;
      rsp_data_in[2*FIELD_W+1]          = changed_ff;
      rsp_data_in[2*FIELD_W+2]          = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         run_id_ff    <= '0;
         run_lvl_ff   <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_READY;
      end else begin
         mask_ff      <= mask_in;
         run_id_ff    <= run_id_in;
         run_lvl_ff   <= run_lvl_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      lvl_ff     <= lvl_in;
      id_ok_ff   <= id_ok_in;
      pend_ff    <= pend_in;
      changed_ff <= changed_in;
      err_ff     <= err_in;
      if (ctl.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;
   assign sts.req_cmd    = cmd_type'(req_tdata[1:0]);
   assign sts.cmd        = cmd_ff;
   assign sts.run_active = active_ff;
   assign sts.preempt    = id_ok_ff & active_ff & (lvl_ff < run_lvl_ff);
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_tready;

endmodule

// ===== rtl/core/priority_ready_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top
// task scheduler with one linked ready queue per priority level
// ----------------------------------------------------------------------------
// commands: a request is captured in idle, then steps through push, re-queue and
// pop as it needs and ends in done, where the result is loaded once the response
// slot is free; one command at a time, set by the push/re-queue/pop steps that
// share the single write port of each queue table
// reset: synchronous, clears ready mask, running state and response valid; queue
// tables hold no reset value, so no clearing pass is needed
module priority_ready_queue_scheduler_top
   import prqs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // cmd, task_id, task_priority
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // run_task, run_priority, switch_pending,
                                         // task_changed, status
);

   prqs_ctl_type ctl;
   prqs_sts_type sts;

   prqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   prqs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule
